### design/losu_pkg.sv
package losu_pkg;

  // Field widths
  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = 25;
  localparam int unsigned RangeW = 25;
  localparam int unsigned DirW   = 16;
  localparam int unsigned SqW    = 51;
  localparam int unsigned QW     = 16;
  localparam int unsigned CfgW   = 25;
  localparam int unsigned IdxW   = 2;

  // Register indexes
  localparam logic [IdxW-1:0] RegPosX     = 2'd0;
  localparam logic [IdxW-1:0] RegPosY     = 2'd1;
  localparam logic [IdxW-1:0] RegPosZ     = 2'd2;
  localparam logic [IdxW-1:0] RegMinRange = 2'd3;

  localparam logic signed [DirW-1:0] DirOne = 16'sd32767;

  typedef struct packed {
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic signed [CoordW-1:0] target_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [DirW-1:0]   dir_x;
    logic signed [DirW-1:0]   dir_y;
    logic signed [DirW-1:0]   dir_z;
    logic        [RangeW-1:0] slant_range;
    logic                     degenerate;
  } out_beat_t;

  // Square root cell payload
  typedef struct packed {
    logic              vld;
    logic [SqW+1:0]    rem;
    logic [RangeW-1:0] root;
  } sqrt_beat_t;

  // Divide cell payload (three lanes sharing one divisor)
  typedef struct packed {
    logic                 vld;
    logic [RangeW-1:0]    den;
    logic [2:0]           neg;
    logic [2:0][RangeW:0] rem;
    logic [2:0][DiffW+QW-1:0] num;
    logic [2:0][QW:0]     quo;
    logic [RangeW-1:0]    rng;
    logic                 degen;
  } div_beat_t;

endpackage

### design/line_of_sight_unit_vector.sv
// Line-of-sight unit vector and slant range.
// Input: pulse start with a target point on in_beat while busy is low; busy
// is always low, so a point may be given every cycle.
// Output: done is high for one cycle with out_beat holding the three Q1.15
// direction components, the floor square-root range and the degenerate flag.
// The pipeline has 1 difference stage, 3 squaring stages, 25 square-root
// cells, 1 compare stage, 41 divide cells and 1 output stage.
// Throughput is one point per cycle; every cell passes its beat on each clock.
// Configuration: cfg_we with cfg_index 0..2 sets the radar x/y/z site and 3
// sets min_range; other indexes are ignored. Write only while idle.
// Reset clears the site to zero, min_range to one and flushes all in-flight
// beats. The receiver cannot stall: results must be taken when done is high.
module line_of_sight_unit_vector (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  losu_pkg::in_beat_t           in_beat,
  output logic                         done,
  output losu_pkg::out_beat_t          out_beat,
  input  logic                         cfg_we,
  input  logic [losu_pkg::IdxW-1:0]    cfg_index,
  input  logic [losu_pkg::CfgW-1:0]    cfg_data
);
  import losu_pkg::*;

  localparam int unsigned NumW = DiffW + QW;
  localparam int unsigned DivSteps = NumW;

  logic signed [CoordW-1:0] pos_x, pos_y, pos_z;
  logic        [RangeW-1:0] min_range;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
      min_range <= RangeW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        RegPosX:     pos_x <= cfg_data[CoordW-1:0];
        RegPosY:     pos_y <= cfg_data[CoordW-1:0];
        RegPosZ:     pos_z <= cfg_data[CoordW-1:0];
        RegMinRange: min_range <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 1: differences
  logic              s1_vld;
  logic signed [DiffW-1:0] s1_d [3];
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= start;
    s1_d[0] <= DiffW'(in_beat.target_x) - DiffW'(pos_x);
    s1_d[1] <= DiffW'(in_beat.target_y) - DiffW'(pos_y);
    s1_d[2] <= DiffW'(in_beat.target_z) - DiffW'(pos_z);
  end

  // Stage 2: magnitudes and signs
  logic s2_vld;
  logic [DiffW-1:0] s2_m [3];
  logic [2:0] s2_neg;
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
    for (int i = 0; i < 3; i++) begin
      s2_neg[i] <= s1_d[i][DiffW-1];
      s2_m[i]   <= s1_d[i][DiffW-1] ? DiffW'(-s1_d[i]) : s1_d[i];
    end
  end

  // Stage 3: squares (25x25 each)
  logic s3_vld;
  logic [2*DiffW-1:0] s3_sq [3];
  logic [DiffW-1:0]   s3_m [3];
  logic [2:0]         s3_neg;
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else     s3_vld <= s2_vld;
    for (int i = 0; i < 3; i++) begin
      s3_sq[i] <= s2_m[i] * s2_m[i];
      s3_m[i]  <= s2_m[i];
    end
    s3_neg <= s2_neg;
  end

  // Stage 4: sum of squares
  logic s4_vld;
  logic [SqW-1:0]   s4_sum;
  logic [DiffW-1:0] s4_m [3];
  logic [2:0]       s4_neg;
  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else     s4_vld <= s3_vld;
    s4_sum <= SqW'(s3_sq[0]) + SqW'(s3_sq[1]) + SqW'(s3_sq[2]);
    s4_m   <= s3_m;
    s4_neg <= s3_neg;
  end

  // Square-root cell chain; magnitudes ride along in a delay line
  sqrt_beat_t       sq_chain [RangeW+1];
  logic [SqW-1:0]   sq_val   [RangeW+1];
  logic [DiffW-1:0] m_line   [RangeW+1][3];
  logic [2:0]       n_line   [RangeW+1];

  always_comb begin
    sq_chain[0].vld  = s4_vld;
    sq_chain[0].rem  = '0;
    sq_chain[0].root = '0;
    sq_val[0]        = s4_sum;
    m_line[0]        = s4_m;
    n_line[0]        = s4_neg;
  end

  for (genvar k = 0; k < RangeW; k++) begin : g_sqrt
    losu_sqrt_cell #(.Step(k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .din    (sq_chain[k]),
      .sq_in  (sq_val[k]),
      .sq_out (sq_val[k+1]),
      .dout   (sq_chain[k+1])
    );
    always_ff @(posedge clk) begin
      m_line[k+1] <= m_line[k];
      n_line[k+1] <= n_line[k];
    end
  end

  // Degenerate compare and divider load; dividend is magnitude times 32768
  div_beat_t dv [DivSteps+1];
  logic [RangeW-1:0] rng;
  assign rng = sq_chain[RangeW].root;

  always_ff @(posedge clk) begin
    if (rst) dv[0].vld <= 1'b0;
    else     dv[0].vld <= sq_chain[RangeW].vld;
    dv[0].den   <= (rng == '0) ? RangeW'(1) : rng;
    dv[0].neg   <= n_line[RangeW];
    dv[0].rng   <= rng;
    dv[0].degen <= (rng < min_range) || (rng == '0);
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] <= '0;
      dv[0].quo[i] <= '0;
      dv[0].num[i] <= {1'b0, m_line[RangeW][i], {(QW-1){1'b0}}};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    losu_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (dv[k]),
      .dout (dv[k+1])
    );
  end

  // Saturate, sign and select fallback
  div_beat_t fin;
  logic signed [DirW-1:0] dir [3];
  logic [QW:0] qs;
  assign fin = dv[DivSteps];

  always_comb begin
    qs = '0;
    for (int i = 0; i < 3; i++) begin
      qs = (fin.quo[i] > (QW+1)'(DirOne)) ? (QW+1)'(DirOne) : fin.quo[i];
      dir[i] = fin.neg[i] ? DirW'(-qs[QW-1:0]) : DirW'(qs[QW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= fin.vld;
    out_beat.slant_range <= fin.rng;
    out_beat.degenerate  <= fin.degen;
    if (fin.degen) begin
      out_beat.dir_x <= '0;
      out_beat.dir_y <= '0;
      out_beat.dir_z <= DirOne;
    end else begin
      out_beat.dir_x <= dir[0];
      out_beat.dir_y <= dir[1];
      out_beat.dir_z <= dir[2];
    end
  end

  // Checks
  a_degen_dir: assert property (@(posedge clk) disable iff (rst)
    done && out_beat.degenerate |-> out_beat.dir_z == DirOne && out_beat.dir_x == '0)
    else $error("fallback direction wrong");
  a_zero_degen: assert property (@(posedge clk) disable iff (rst)
    done && out_beat.slant_range == '0 |-> out_beat.degenerate)
    else $error("zero range not degenerate");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    done |-> out_beat.dir_x != 16'sh8000 && out_beat.dir_y != 16'sh8000)
    else $error("direction out of range");
  a_sqrt_flow: assert property (@(posedge clk) disable iff (rst)
    sq_chain[0].vld |-> ##(RangeW) sq_chain[RangeW].vld)
    else $error("sqrt beat lost");

endmodule

### design/losu_sqrt_cell.sv
// One restoring square-root step: brings down two bits, produces one root bit.
module losu_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  losu_pkg::sqrt_beat_t        din,
  input  logic [losu_pkg::SqW-1:0]    sq_in,
  output logic [losu_pkg::SqW-1:0]    sq_out,
  output losu_pkg::sqrt_beat_t        dout
);
  import losu_pkg::*;

  localparam int unsigned Sh = 2 * (RangeW - 1 - Step);

  logic [SqW+1:0]    trial;
  logic [SqW+1:0]    rem_sh;
  logic [1:0]        pair;
  sqrt_beat_t        nxt;
  logic [SqW-1:0]    sq_sh;

  always_comb begin
    sq_sh  = sq_in >> Sh;
    pair   = sq_sh[1:0];
    rem_sh = {din.rem[SqW-1:0], pair};
    trial  = {{(SqW+2-RangeW-2){1'b0}}, din.root, 2'b01};
    nxt    = din;
    if (rem_sh >= trial) begin
      nxt.rem  = rem_sh - trial;
      nxt.root = {din.root[RangeW-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh;
      nxt.root = {din.root[RangeW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.rem  <= nxt.rem;
    dout.root <= nxt.root;
    sq_out    <= sq_in;
  end

endmodule

### design/losu_div_cell.sv
// One restoring divide step on all three lanes, one quotient bit each.
module losu_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  losu_pkg::div_beat_t  din,
  output losu_pkg::div_beat_t  dout
);
  import losu_pkg::*;

  localparam int unsigned NumW = DiffW + QW;

  div_beat_t  nxt;
  logic [RangeW:0] sh;

  always_comb begin
    nxt = din;
    sh  = '0;
    for (int i = 0; i < 3; i++) begin
      sh = {din.rem[i][RangeW-1:0], din.num[i][NumW-1]};
      nxt.num[i] = {din.num[i][NumW-2:0], 1'b0};
      if (sh >= {1'b0, din.den}) begin
        nxt.rem[i] = sh - {1'b0, din.den};
        nxt.quo[i] = {din.quo[i][QW-1:0], 1'b1};
      end else begin
        nxt.rem[i] = sh;
        nxt.quo[i] = {din.quo[i][QW-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.den   <= nxt.den;
    dout.neg   <= nxt.neg;
    dout.rem   <= nxt.rem;
    dout.num   <= nxt.num;
    dout.quo   <= nxt.quo;
    dout.rng   <= nxt.rng;
    dout.degen <= nxt.degen;
  end

endmodule
